// ===== design/median_filter_3x3_macros.svh =====
// Assertion helpers shared by the filter modules.
`ifndef MEDIAN_FILTER_3X3_MACROS_SVH
`define MEDIAN_FILTER_3X3_MACROS_SVH

// Same-cycle implication.
`define MF3_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define MF3_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== design/mf3_pkg.sv =====
package mf3_pkg;

   localparam int MAX_WIDTH_DEF  = 2048;
   localparam int MAX_HEIGHT_DEF = 2048;

   localparam int PIX_W     = 8;
   localparam int POS_W     = 11;
   localparam int CFG_W     = 12;
   localparam int CSR_IDX_W = 1;

   localparam logic [CFG_W-1:0] WIDTH_RESET  = CFG_W'(640);
   localparam logic [CFG_W-1:0] HEIGHT_RESET = CFG_W'(480);
   localparam int               MIN_DIM      = 3;

   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_WIDTH  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_HEIGHT = 1'b1;

   typedef struct packed {
      logic [POS_W-1:0] row;
      logic [POS_W-1:0] column;
      logic             done;
   } meta_type;

   typedef struct packed {
      logic [PIX_W-1:0] pixel;
      logic             emit;
      meta_type         meta;
   } pixel_item_type;

   typedef struct packed {
      logic [PIX_W-1:0] lo;
      logic [PIX_W-1:0] md;
      logic [PIX_W-1:0] hi;
   } trio_type;

   typedef trio_type [2:0] rows_type;

   function automatic trio_type sort3(input logic [PIX_W-1:0] a,
                                      input logic [PIX_W-1:0] b,
                                      input logic [PIX_W-1:0] c);
      logic [PIX_W-1:0] x;
      logic [PIX_W-1:0] y;
      logic [PIX_W-1:0] z;
      logic [PIX_W-1:0] t;
      trio_type         r;
      x = a;
      y = b;
      z = c;
      if (x > y) begin
         t = x; x = y; y = t;
      end
      if (y > z) begin
         t = y; y = z; z = t;
      end
      if (x > y) begin
         t = x; x = y; y = t;
      end
      r.lo = x;
      r.md = y;
      r.hi = z;
      return r;
   endfunction

   function automatic logic [PIX_W-1:0] max2(input logic [PIX_W-1:0] a,
                                             input logic [PIX_W-1:0] b);
      return (a > b) ? a : b;
   endfunction

   function automatic logic [PIX_W-1:0] min2(input logic [PIX_W-1:0] a,
                                             input logic [PIX_W-1:0] b);
      return (a < b) ? a : b;
   endfunction

   function automatic logic [PIX_W-1:0] med3(input logic [PIX_W-1:0] a,
                                             input logic [PIX_W-1:0] b,
                                             input logic [PIX_W-1:0] c);
      return max2(min2(a, b), min2(max2(a, b), c));
   endfunction

endpackage

// ===== design/mf3_ram.sv =====
module mf3_ram #(
   parameter int WIDTH  = mf3_pkg::PIX_W,
   parameter int DEPTH  = mf3_pkg::MAX_WIDTH_DEF,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // read-first on a same-address collision
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/mf3_line_window.sv =====
`include "median_filter_3x3_macros.svh"

module mf3_line_window #(
   parameter int MAX_WIDTH = mf3_pkg::MAX_WIDTH_DEF,
   localparam int AW = $clog2(MAX_WIDTH)
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   advance,
   input  logic                   accept,
   input  logic [AW-1:0]          rd_addr,
   input  mf3_pkg::pixel_item_type item_in,
   output logic                   s2_valid,
   output mf3_pkg::rows_type       s2_rows,
   output mf3_pkg::meta_type       s2_meta
);

   localparam int PW = mf3_pkg::PIX_W;

   logic                    a_valid_ff;
   logic [AW-1:0]           a_addr_ff;
   mf3_pkg::pixel_item_type a_item_ff;
   logic                    fwd_ff;
   logic                    fwd_in;
   logic [PW-1:0]           fwd_top_ff;
   logic [PW-1:0]           fwd_mid_ff;
   logic [8:0][PW-1:0]      window_ff;
   logic [8:0][PW-1:0]      window_in;
   logic                    s2_valid_ff;
   mf3_pkg::rows_type       s2_rows_ff;
   mf3_pkg::rows_type       s2_rows_in;
   mf3_pkg::meta_type       s2_meta_ff;

   logic [PW-1:0] two_rd;
   logic [PW-1:0] one_rd;
   logic [PW-1:0] top_px;
   logic [PW-1:0] mid_px;
   logic          wr_en;

   assign wr_en = advance && a_valid_ff;

   mf3_ram #(.WIDTH(PW), .DEPTH(MAX_WIDTH)) u_two_above (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (a_addr_ff),
      .wr_data (mid_px),
      .rd_en   (accept),
      .rd_addr (rd_addr),
      .rd_data (two_rd)
   );

   mf3_ram #(.WIDTH(PW), .DEPTH(MAX_WIDTH)) u_above (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (a_addr_ff),
      .wr_data (a_item_ff.pixel),
      .rd_en   (accept),
      .rd_addr (rd_addr),
      .rd_data (one_rd)
   );

   // back-to-back hit on the address being written: read returned stale data
   assign fwd_in = accept && a_valid_ff && (a_addr_ff == rd_addr);
   assign top_px = fwd_ff ? fwd_top_ff : two_rd;
   assign mid_px = fwd_ff ? fwd_mid_ff : one_rd;

   always_comb begin
      window_in    = window_ff;
      window_in[0] = window_ff[1];
      window_in[1] = window_ff[2];
      window_in[2] = top_px;
      window_in[3] = window_ff[4];
      window_in[4] = window_ff[5];
      window_in[5] = mid_px;
      window_in[6] = window_ff[7];
      window_in[7] = window_ff[8];
      window_in[8] = a_item_ff.pixel;
      s2_rows_in[0] = mf3_pkg::sort3(window_in[0], window_in[1], window_in[2]);
      s2_rows_in[1] = mf3_pkg::sort3(window_in[3], window_in[4], window_in[5]);
      s2_rows_in[2] = mf3_pkg::sort3(window_in[6], window_in[7], window_in[8]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff  <= 1'b0;
         fwd_ff      <= 1'b0;
         s2_valid_ff <= 1'b0;
         window_ff   <= '0;
      end else if (advance) begin
         a_valid_ff  <= accept;
         fwd_ff      <= fwd_in;
         s2_valid_ff <= a_valid_ff && a_item_ff.emit;
         if (a_valid_ff) begin
            window_ff <= window_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         a_addr_ff  <= rd_addr;
         a_item_ff  <= item_in;
         fwd_top_ff <= mid_px;
         fwd_mid_ff <= a_item_ff.pixel;
         s2_rows_ff <= s2_rows_in;
         s2_meta_ff <= a_item_ff.meta;
      end
   end

   assign s2_valid = s2_valid_ff;
   assign s2_rows  = s2_rows_ff;
   assign s2_meta  = s2_meta_ff;

   `MF3_ASSERT_IMPLY(a_fwd_needs_item, clock, reset, fwd_ff, a_valid_ff, "forward without item")
   `MF3_ASSERT_NEXT(a_no_s2_from_bubble, clock, reset, advance && !a_valid_ff, !s2_valid_ff, "result from empty stage")

endmodule

// ===== design/mf3_median_select.sv =====
`include "median_filter_3x3_macros.svh"

module mf3_median_select (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         advance,
   input  logic                         s2_valid,
   input  mf3_pkg::rows_type             s2_rows,
   input  mf3_pkg::meta_type             s2_meta,
   output logic                         out_valid,
   output logic [mf3_pkg::PIX_W-1:0]    out_median,
   output mf3_pkg::meta_type             out_meta
);

   localparam int PW = mf3_pkg::PIX_W;

   logic              s3_valid_ff;
   mf3_pkg::trio_type s3_trio_ff;
   mf3_pkg::trio_type s3_trio_in;
   mf3_pkg::meta_type s3_meta_ff;
   logic              out_valid_ff;
   logic [PW-1:0]     out_median_ff;
   logic [PW-1:0]     out_median_in;
   mf3_pkg::meta_type out_meta_ff;

   // max of row minima, median of row medians, min of row maxima
   always_comb begin
      s3_trio_in.lo = mf3_pkg::max2(mf3_pkg::max2(s2_rows[0].lo, s2_rows[1].lo), s2_rows[2].lo);
      s3_trio_in.md = mf3_pkg::med3(s2_rows[0].md, s2_rows[1].md, s2_rows[2].md);
      s3_trio_in.hi = mf3_pkg::min2(mf3_pkg::min2(s2_rows[0].hi, s2_rows[1].hi), s2_rows[2].hi);
      out_median_in = mf3_pkg::med3(s3_trio_ff.lo, s3_trio_ff.md, s3_trio_ff.hi);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         s3_valid_ff  <= s2_valid;
         out_valid_ff <= s3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s3_trio_ff    <= s3_trio_in;
         s3_meta_ff    <= s2_meta;
         out_median_ff <= out_median_in;
         out_meta_ff   <= s3_meta_ff;
      end
   end

   assign out_valid  = out_valid_ff;
   assign out_median = out_median_ff;
   assign out_meta   = out_meta_ff;

   `MF3_ASSERT_NEXT(a_s3_reaches_out, clock, reset, advance && s3_valid_ff, out_valid_ff, "result lost")

endmodule

// ===== design/median_filter_3x3.sv =====
// Streaming 3x3 median filter, one pixel per clock sustained.
// Pipeline: after its pixel transaction is accepted, a result is registered in turn
// through line-store read, row sort, median-of-medians and output register.
// Throughput: 1 pixel per cycle; a stall on the result side holds the whole pipeline.
// Reset: synchronous, active high; clears counters, window, valids and loads
// frame_width 640 / frame_height 480. Line stores are not cleared.
`include "median_filter_3x3_macros.svh"

module median_filter_3x3 #(
   parameter int MAX_WIDTH  = mf3_pkg::MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT = mf3_pkg::MAX_HEIGHT_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [mf3_pkg::PIX_W-1:0]     req_pixel_value,
   input  logic                          req_frame_start,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [mf3_pkg::PIX_W-1:0]     rsp_median_value,
   output logic [mf3_pkg::POS_W-1:0]     rsp_out_row,
   output logic [mf3_pkg::POS_W-1:0]     rsp_out_column,
   output logic                          rsp_frame_done,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [mf3_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [mf3_pkg::CFG_W-1:0]     csr_data
);

   localparam int CNT_W  = $clog2(MAX_WIDTH);
   localparam int ROW_W  = $clog2(MAX_HEIGHT);
   localparam int DW_W   = $clog2(MAX_WIDTH + 1);
   localparam int DH_W   = $clog2(MAX_HEIGHT + 1);
   localparam int CW0    = (DW_W > mf3_pkg::CFG_W) ? DW_W : mf3_pkg::CFG_W;
   localparam int CW     = (DH_W > CW0) ? DH_W : CW0;

   logic [mf3_pkg::CFG_W-1:0] width_ff;
   logic [mf3_pkg::CFG_W-1:0] height_ff;

   logic [CW-1:0] w_raw;
   logic [CW-1:0] h_raw;
   logic [CW-1:0] w_eff;
   logic [CW-1:0] h_eff;

   logic [CNT_W-1:0] col_ff;
   logic [CNT_W-1:0] col_in;
   logic [CNT_W-1:0] col_cur;
   logic [ROW_W-1:0] row_ff;
   logic [ROW_W-1:0] row_in;
   logic [ROW_W-1:0] row_cur;
   logic [CW-1:0]    col_ext;
   logic [CW-1:0]    row_ext;
   logic [CW-1:0]    col_inc;
   logic [CW-1:0]    row_inc;

   logic                    advance;
   logic                    accept;
   mf3_pkg::pixel_item_type item;

   logic              s2_valid;
   mf3_pkg::rows_type s2_rows;
   mf3_pkg::meta_type s2_meta;
   mf3_pkg::meta_type out_meta;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= mf3_pkg::WIDTH_RESET;
         height_ff <= mf3_pkg::HEIGHT_RESET;
      end else if (csr_valid) begin
         unique case (csr_index)
            mf3_pkg::CSR_FRAME_WIDTH:  width_ff  <= csr_data;
            mf3_pkg::CSR_FRAME_HEIGHT: height_ff <= csr_data;
         endcase
      end
   end

   always_comb begin
      w_raw = CW'(width_ff);
      h_raw = CW'(height_ff);
      if (w_raw < CW'(mf3_pkg::MIN_DIM)) begin
         w_eff = CW'(mf3_pkg::MIN_DIM);
      end else if (w_raw > CW'(MAX_WIDTH)) begin
         w_eff = CW'(MAX_WIDTH);
      end else begin
         w_eff = w_raw;
      end
      if (h_raw < CW'(mf3_pkg::MIN_DIM)) begin
         h_eff = CW'(mf3_pkg::MIN_DIM);
      end else if (h_raw > CW'(MAX_HEIGHT)) begin
         h_eff = CW'(MAX_HEIGHT);
      end else begin
         h_eff = h_raw;
      end
   end

   // whole pipeline moves together; it moves whenever the output slot is free
   assign advance   = !rsp_valid || !rsp_stall;
   assign req_stall = !advance;
   assign accept    = req_valid && advance;

   always_comb begin
      col_cur = req_frame_start ? '0 : col_ff;
      row_cur = req_frame_start ? '0 : row_ff;
      col_ext = CW'(col_cur);
      row_ext = CW'(row_cur);
      col_inc = col_ext + CW'(1);
      row_inc = row_ext + CW'(1);
      if (col_inc >= w_eff) begin
         col_in = '0;
         row_in = (row_inc >= h_eff) ? '0 : ROW_W'(row_inc);
      end else begin
         col_in = CNT_W'(col_inc);
         row_in = row_cur;
      end
      item.pixel       = req_pixel_value;
      item.emit        = (row_ext >= CW'(2)) && (col_ext >= CW'(2));
      item.meta.row    = mf3_pkg::POS_W'(row_ext - CW'(1));
      item.meta.column = mf3_pkg::POS_W'(col_ext - CW'(1));
      item.meta.done   = (row_ext == h_eff - CW'(1)) && (col_ext == w_eff - CW'(1));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else if (accept) begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   mf3_line_window #(.MAX_WIDTH(MAX_WIDTH)) u_window (
      .clock    (clock),
      .reset    (reset),
      .advance  (advance),
      .accept   (accept),
      .rd_addr  (col_cur),
      .item_in  (item),
      .s2_valid (s2_valid),
      .s2_rows  (s2_rows),
      .s2_meta  (s2_meta)
   );

   mf3_median_select u_select (
      .clock      (clock),
      .reset      (reset),
      .advance    (advance),
      .s2_valid   (s2_valid),
      .s2_rows    (s2_rows),
      .s2_meta    (s2_meta),
      .out_valid  (rsp_valid),
      .out_median (rsp_median_value),
      .out_meta   (out_meta)
   );

   assign rsp_out_row    = out_meta.row;
   assign rsp_out_column = out_meta.column;
   assign rsp_frame_done = out_meta.done;

   `MF3_ASSERT_NEXT(a_frame_start_pos, clock, reset, req_valid && !req_stall && req_frame_start, col_ff == CNT_W'(1) && row_ff == '0, "frame start position")
   `MF3_ASSERT_IMPLY(a_col_bound, clock, reset, 1'b1, CW'(col_ff) < CW'(MAX_WIDTH), "column past line store")

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 100ps

module testbench;

   localparam int MAX_W     = mf3_pkg::MAX_WIDTH_DEF;
   localparam int MAX_H     = mf3_pkg::MAX_HEIGHT_DEF;
   localparam int LIMIT     = 800000;
   localparam int HOLD_LEN  = 300;
   localparam int SETTLE    = 8;

   typedef struct packed {
      logic [mf3_pkg::PIX_W-1:0] pixel;
      logic                      frame_start;
   } pixel_txn_type;

   typedef struct packed {
      logic [mf3_pkg::PIX_W-1:0] median;
      logic [mf3_pkg::POS_W-1:0] row;
      logic [mf3_pkg::POS_W-1:0] column;
      logic                      done;
   } median_type;

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          req_valid = 1'b0;
   logic                          req_stall;
   logic [mf3_pkg::PIX_W-1:0]     req_pixel_value = '0;
   logic                          req_frame_start = 1'b0;
   logic                          rsp_valid;
   logic                          rsp_stall = 1'b0;
   logic [mf3_pkg::PIX_W-1:0]     rsp_median_value;
   logic [mf3_pkg::POS_W-1:0]     rsp_out_row;
   logic [mf3_pkg::POS_W-1:0]     rsp_out_column;
   logic                          rsp_frame_done;
   logic                          csr_valid = 1'b0;
   logic                          csr_ready;
   logic [mf3_pkg::CSR_IDX_W-1:0] csr_index = '0;
   logic [mf3_pkg::CFG_W-1:0]     csr_data = '0;

   median_filter_3x3 dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_pixel_value  (req_pixel_value),
      .req_frame_start  (req_frame_start),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_median_value (rsp_median_value),
      .rsp_out_row      (rsp_out_row),
      .rsp_out_column   (rsp_out_column),
      .rsp_frame_done   (rsp_frame_done),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data)
   );

   always #6 clock = ~clock;

   pixel_txn_type pixel_backlog[$];
   median_type    expected_medians[$];
   pixel_txn_type next_txn;
   int            errors = 0;
   int            cycle_count = 0;
   int            send_idle_pct = 0;
   int            recv_idle_pct = 0;
   int            hold_requests = 0;
   int            hold_seen = 0;
   int            hold_left = 0;

   // predictor state, follows accepted transactions
   logic [mf3_pkg::PIX_W-1:0] above_line [MAX_W];
   logic [mf3_pkg::PIX_W-1:0] two_above_line [MAX_W];
   logic [mf3_pkg::PIX_W-1:0] win [9];
   int                        cur_col = 0;
   int                        cur_row = 0;
   logic [mf3_pkg::CFG_W-1:0] pred_w = mf3_pkg::WIDTH_RESET;
   logic [mf3_pkg::CFG_W-1:0] pred_h = mf3_pkg::HEIGHT_RESET;

   // stimulus-side position tracking, keeps line store reads on written entries
   int                        gen_col = 0;
   int                        gen_row = 0;
   logic [mf3_pkg::CFG_W-1:0] gen_w = mf3_pkg::WIDTH_RESET;
   logic [mf3_pkg::CFG_W-1:0] gen_h = mf3_pkg::HEIGHT_RESET;
   int                        prime_count [MAX_W];

   function automatic int limit_dim(input logic [mf3_pkg::CFG_W-1:0] v, input int hi);
      if (v < mf3_pkg::MIN_DIM) return mf3_pkg::MIN_DIM;
      if (v > hi) return hi;
      return int'(v);
   endfunction

   task automatic step_position(inout int col, inout int row, input int w, input int h);
      col++;
      if (col >= w) begin
         col = 0;
         row++;
         if (row >= h) row = 0;
      end
   endtask

   // rank 4: the value with at most four smaller and at least five not larger
   function automatic logic [mf3_pkg::PIX_W-1:0] window_median();
      int lt;
      int eq;
      for (int i = 0; i < 9; i++) begin
         lt = 0;
         eq = 0;
         for (int j = 0; j < 9; j++) begin
            if (win[j] < win[i]) lt++;
            else if (win[j] == win[i]) eq++;
         end
         if (lt <= 4 && lt + eq > 4) return win[i];
      end
      return '0;
   endfunction

   task automatic filter_pixel(input logic [mf3_pkg::PIX_W-1:0] px, input logic fs);
      int                        w;
      int                        h;
      int                        addr;
      logic [mf3_pkg::PIX_W-1:0] top;
      logic [mf3_pkg::PIX_W-1:0] mid;
      median_type                res;
      w = limit_dim(pred_w, MAX_W);
      h = limit_dim(pred_h, MAX_H);
      if (fs) begin
         cur_col = 0;
         cur_row = 0;
      end
      addr = cur_col % MAX_W;
      top = two_above_line[addr];
      mid = above_line[addr];
      for (int k = 0; k < 9; k += 3) begin
         win[k] = win[k+1];
         win[k+1] = win[k+2];
      end
      win[2] = top;
      win[5] = mid;
      win[8] = px;
      two_above_line[addr] = mid;
      above_line[addr] = px;
      if (cur_row >= 2 && cur_col >= 2) begin
         res.median = window_median();
         res.row = mf3_pkg::POS_W'(cur_row - 1);
         res.column = mf3_pkg::POS_W'(cur_col - 1);
         res.done = (cur_row == h - 1) && (cur_col == w - 1);
         expected_medians.push_back(res);
      end
      step_position(cur_col, cur_row, w, h);
   endtask

   task automatic report_mismatch(input string msg);
      $display("MISMATCH at %0t: %s", $time, msg);
      errors++;
   endtask

   task automatic check_median();
      median_type want;
      if (expected_medians.size() == 0) begin
         report_mismatch($sformatf("unexpected result row %0d col %0d",
                                   rsp_out_row, rsp_out_column));
      end else begin
         want = expected_medians.pop_front();
         if (rsp_median_value !== want.median)
            report_mismatch($sformatf("median %0d, want %0d at row %0d col %0d",
                                      rsp_median_value, want.median, want.row, want.column));
         if (rsp_out_row !== want.row)
            report_mismatch($sformatf("out_row %0d, want %0d", rsp_out_row, want.row));
         if (rsp_out_column !== want.column)
            report_mismatch($sformatf("out_column %0d, want %0d at row %0d",
                                      rsp_out_column, want.column, want.row));
         if (rsp_frame_done !== want.done)
            report_mismatch($sformatf("frame_done %0b, want %0b at row %0d col %0d",
                                      rsp_frame_done, want.done, want.row, want.column));
      end
   endtask

   // pixel driver; prediction runs on each accepted transaction
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) filter_pixel(req_pixel_value, req_frame_start);
         if (!req_valid || !req_stall) begin
            if (pixel_backlog.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
               next_txn = pixel_backlog.pop_front();
               req_valid <= 1'b1;
               req_pixel_value <= next_txn.pixel;
               req_frame_start <= next_txn.frame_start;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // result monitor and receiver stall, including the long hold-off
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         hold_left <= 0;
      end else begin
         if (rsp_valid && !rsp_stall) check_median();
         if (hold_seen != hold_requests) begin
            hold_seen <= hold_requests;
            hold_left <= HOLD_LEN;
            rsp_stall <= 1'b1;
         end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= ($urandom_range(0, 99) < recv_idle_pct);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= LIMIT) begin
         $display("TIMEOUT after %0d cycles", cycle_count);
         $display("== FAIL ==");
         $finish;
      end
   end

   task automatic write_reg(input logic [mf3_pkg::CSR_IDX_W-1:0] idx,
                            input logic [mf3_pkg::CFG_W-1:0] data);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= data;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      if (idx == mf3_pkg::CSR_FRAME_WIDTH) pred_w = data;
      else if (idx == mf3_pkg::CSR_FRAME_HEIGHT) pred_h = data;
   endtask

   task automatic wait_idle();
      int guard;
      guard = 0;
      while (pixel_backlog.size() != 0 || req_valid) @(posedge clock);
      while (expected_medians.size() != 0 && guard < 5000) begin
         @(posedge clock);
         guard++;
      end
      if (expected_medians.size() != 0) begin
         report_mismatch($sformatf("%0d results never arrived", expected_medians.size()));
         expected_medians.delete();
      end
      // border pixels may still be in flight with no result
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic set_frame(input logic [mf3_pkg::CFG_W-1:0] w,
                            input logic [mf3_pkg::CFG_W-1:0] h);
      wait_idle();
      write_reg(mf3_pkg::CSR_FRAME_WIDTH, w);
      write_reg(mf3_pkg::CSR_FRAME_HEIGHT, h);
      gen_w = w;
      gen_h = h;
   endtask

   task automatic queue_pixel(input logic [mf3_pkg::PIX_W-1:0] px, input logic fs);
      pixel_txn_type t;
      if (fs) begin
         gen_col = 0;
         gen_row = 0;
      end
      if (prime_count[gen_col % MAX_W] < 2) prime_count[gen_col % MAX_W]++;
      step_position(gen_col, gen_row, limit_dim(gen_w, MAX_W), limit_dim(gen_h, MAX_H));
      t.pixel = px;
      t.frame_start = fs;
      pixel_backlog.push_back(t);
   endtask

   // both line stores hold written data for every column the next reads can reach
   function automatic bit lines_primed();
      int upto;
      upto = limit_dim(gen_w, MAX_W) - 1;
      if (gen_col > upto) upto = gen_col;
      for (int a = 0; a <= upto; a++)
         if (prime_count[a] < 2) return 1'b0;
      return 1'b1;
   endfunction

   function automatic logic [mf3_pkg::PIX_W-1:0] pick_pixel();
      int r;
      r = $urandom_range(0, 99);
      if (r < 70) return mf3_pkg::PIX_W'($urandom_range(0, 255));
      if (r < 85) return ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00;
      return mf3_pkg::PIX_W'($urandom_range(100, 103));   // ties
   endfunction

   task automatic queue_frame_run(input int count);
      for (int i = 0; i < count; i++) queue_pixel(pick_pixel(), i == 0);
   endtask

   task automatic run_random_phases(input int target);
      int                        queued;
      int                        n;
      int                        r;
      bit                        start_fs;
      logic [mf3_pkg::CFG_W-1:0] w;
      logic [mf3_pkg::CFG_W-1:0] h;
      queued = 0;
      while (queued < target) begin
         r = $urandom_range(0, 99);
         if (r < 8) w = mf3_pkg::CFG_W'($urandom_range(0, 2));
         else if (r < 92) w = mf3_pkg::CFG_W'($urandom_range(3, 12));
         else w = mf3_pkg::CFG_W'($urandom_range(13, 40));
         r = $urandom_range(0, 99);
         if (r < 8) h = mf3_pkg::CFG_W'($urandom_range(0, 2));
         else if (r < 90) h = mf3_pkg::CFG_W'($urandom_range(3, 8));
         else if (r < 95) h = mf3_pkg::CFG_W'($urandom_range(2049, 4095));
         else h = mf3_pkg::CFG_W'($urandom_range(9, 30));
         set_frame(w, h);
         n = $urandom_range(2, 4) * limit_dim(w, MAX_W) * limit_dim(h, 30);
         if (n > 400) n = 400;
         if (n < 20) n = 20;
         // continuing mid-frame after a size change is fine once the stores are primed
         start_fs = !lines_primed() || ($urandom_range(0, 1) != 0);
         for (int i = 0; i < n; i++)
            queue_pixel(pick_pixel(), (i == 0 && start_fs) || $urandom_range(0, 99) < 2);
         queued += n;
      end
   endtask

   initial begin
      for (int a = 0; a < MAX_W; a++) prime_count[a] = 0;
      for (int k = 0; k < 9; k++) win[k] = '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      send_idle_pct = 26;
      recv_idle_pct = 57;
      // directed: smallest frame, extreme values, implicit wrap, restart mid-line
      set_frame(12'd3, 12'd3);
      for (int i = 0; i < 9; i++)
         queue_pixel((i == 8) ? 8'hFF : mf3_pkg::PIX_W'(i * 32), i == 0);
      for (int i = 0; i < 9; i++) queue_pixel(mf3_pkg::PIX_W'(255 - i * 31), 1'b0);
      queue_pixel(8'h00, 1'b0);
      queue_pixel(8'hFF, 1'b0);
      for (int i = 0; i < 9; i++) queue_pixel((i % 2 != 0) ? 8'hFF : 8'h00, i == 0);
      run_random_phases(350);
      // width above the maximum, clamped
      set_frame(12'hFFF, 12'd3);
      queue_frame_run(150);

      send_idle_pct = 57;
      recv_idle_pct = 26;
      // width below minimum, height above maximum
      set_frame(12'h000, 12'hFFF);
      queue_frame_run(200);
      // receiver holds off while the sender keeps offering
      set_frame(12'd6, 12'd5);
      send_idle_pct = 0;
      queue_frame_run(300);
      hold_requests++;
      wait_idle();
      send_idle_pct = 57;
      run_random_phases(100);

      send_idle_pct = 0;
      recv_idle_pct = 0;
      run_random_phases(200);

      wait_idle();
      if (errors == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
